// File: hdl/tddfa_pkg.sv
// shared types and codes for the table driven dfa recognizer
// used by tddfa_front, tddfa_fifo, tddfa_back and the top level
package tddfa_pkg;

    // input opcodes
    localparam logic [2:0] OP_ALPHA = 3'd0;
    localparam logic [2:0] OP_TRANS = 3'd1;
    localparam logic [2:0] OP_SLOT  = 3'd2;
    localparam logic [2:0] OP_CHAR  = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    // kinds of work passed from front to back
    localparam logic [1:0] K_CHAR   = 2'd0;
    localparam logic [1:0] K_TWRITE = 2'd1;
    localparam logic [1:0] K_SWRITE = 2'd2;
    localparam logic [1:0] K_END    = 2'd3;

    localparam int SYM_W       = 8;
    localparam int GROUP       = 16;
    localparam int LOCAL_W     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [6:0] symbol_index;
        logic [5:0] from_state;
        logic [5:0] to_state;
        logic [2:0] slot_number;
        logic       slot_valid;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             found;
        logic [SYM_W-1:0] sym;
        logic             last;
        logic [5:0]       from_state;
        logic [5:0]       to_state;
        logic [2:0]       slot_number;
        logic             slot_valid;
    } entry_t;

endpackage

// File: hdl/tddfa_front.sv
// front end: takes input beats, owns the alphabet store and resolves each
// character to its symbol index through a three stage match pipeline
// depends on tddfa_pkg
module tddfa_front #(
    parameter int ALPHABET_DEPTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tddfa_pkg::item_t    in_item,
    input  logic [7:0]          alphabet_length,
    output logic                q_push,
    output tddfa_pkg::entry_t   q_data,
    input  logic                q_full
);

    localparam int NG  = (ALPHABET_DEPTH + tddfa_pkg::GROUP - 1) / tddfa_pkg::GROUP;
    localparam int PAD = NG * tddfa_pkg::GROUP;

    logic [7:0] alpha_reg [ALPHABET_DEPTH];

    logic advance;
    logic accept;
    logic a_keep;

    logic                  a_valid_reg, b_valid_reg, c_valid_reg;
    tddfa_pkg::entry_t     a_entry_reg, a_entry_next;
    tddfa_pkg::entry_t     b_entry_reg;
    tddfa_pkg::entry_t     c_entry_reg, c_entry_next;
    logic [PAD-1:0]        a_match_reg, a_match_next;
    logic [NG-1:0]         b_found_reg, b_found_next;
    logic [tddfa_pkg::LOCAL_W-1:0] b_idx_reg [NG];
    logic [tddfa_pkg::LOCAL_W-1:0] b_idx_next [NG];

    assign advance  = !c_valid_reg || !q_full;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    // alphabet entries, each written at its own decoded index
    always_ff @(posedge aclk) begin
        for (int j = 0; j < ALPHABET_DEPTH; j++) begin
            if (accept && in_item.opcode == tddfa_pkg::OP_ALPHA &&
                {1'b0, in_item.symbol_index} == 8'(j)) begin
                alpha_reg[j] <= in_item.char_code;
            end
        end
    end

    genvar gj;
    generate
        for (gj = 0; gj < PAD; gj++) begin : g_match
            if (gj < ALPHABET_DEPTH) begin : g_live
                assign a_match_next[gj] = (alpha_reg[gj] == in_item.char_code) &&
                                          (9'(gj) < {1'b0, alphabet_length});
            end else begin : g_pad
                assign a_match_next[gj] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        a_entry_next             = '0;
        a_entry_next.sym         = tddfa_pkg::SYM_W'(in_item.symbol_index);
        a_entry_next.last        = in_item.last;
        a_entry_next.from_state  = in_item.from_state;
        a_entry_next.to_state    = in_item.to_state;
        a_entry_next.slot_number = in_item.slot_number;
        a_entry_next.slot_valid  = in_item.slot_valid;
        a_keep                   = 1'b1;
        case (in_item.opcode)
            tddfa_pkg::OP_TRANS: begin
                a_entry_next.kind = tddfa_pkg::K_TWRITE;
            end
            tddfa_pkg::OP_SLOT: begin
                a_entry_next.kind = tddfa_pkg::K_SWRITE;
            end
            tddfa_pkg::OP_CHAR: begin
                a_entry_next.kind = tddfa_pkg::K_CHAR;
            end
            tddfa_pkg::OP_END: begin
                a_entry_next.kind = tddfa_pkg::K_END;
            end
            default: begin
                // alphabet writes finish here, unused opcodes vanish
                a_entry_next.kind = tddfa_pkg::K_END;
                a_keep            = 1'b0;
            end
        endcase
    end

    // per group: any hit and the lowest hit inside the group
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            b_found_next[g] = |a_match_reg[g*tddfa_pkg::GROUP +: tddfa_pkg::GROUP];
            b_idx_next[g]   = '0;
            for (int i = tddfa_pkg::GROUP - 1; i >= 0; i--) begin
                if (a_match_reg[g*tddfa_pkg::GROUP + i]) begin
                    b_idx_next[g] = tddfa_pkg::LOCAL_W'(i);
                end
            end
        end
    end

    // lowest group with a hit gives the symbol
    always_comb begin
        c_entry_next = b_entry_reg;
        if (b_entry_reg.kind == tddfa_pkg::K_CHAR) begin
            c_entry_next.found = 1'b0;
            c_entry_next.sym   = '0;
            for (int g = NG - 1; g >= 0; g--) begin
                if (b_found_reg[g]) begin
                    c_entry_next.found = 1'b1;
                    c_entry_next.sym   = tddfa_pkg::SYM_W'(g * tddfa_pkg::GROUP) +
                                         tddfa_pkg::SYM_W'(b_idx_reg[g]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= accept && a_keep;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_entry_reg <= a_entry_next;
            a_match_reg <= a_match_next;
            b_entry_reg <= a_entry_reg;
            b_found_reg <= b_found_next;
            b_idx_reg   <= b_idx_next;
            c_entry_reg <= c_entry_next;
        end
    end

    assign q_push = c_valid_reg && !q_full;
    assign q_data = c_entry_reg;

endmodule

// File: hdl/tddfa_fifo.sv
// short queue of resolved work between the front end and the back end
// depends on tddfa_pkg
module tddfa_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  tddfa_pkg::entry_t  push_data,
    output logic               full,
    input  logic               pop,
    output tddfa_pkg::entry_t  pop_data,
    output logic               empty
);

    tddfa_pkg::entry_t               buf_reg [tddfa_pkg::QUEUE_DEPTH];
    logic [tddfa_pkg::QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [tddfa_pkg::QPTR_W:0]      count_reg;

    assign full     = count_reg == (tddfa_pkg::QPTR_W + 1)'(tddfa_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = buf_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/tddfa_back.sv
// back end: transition memory, accept slots, current state and reject flag,
// plus the result register; depends on tddfa_pkg
module tddfa_back #(
    parameter int NUM_STATES     = 64,
    parameter int ALPHABET_DEPTH = 128,
    parameter int ACCEPT_SLOTS   = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  tddfa_pkg::entry_t  q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_accepted,
    output logic               out_bad
);

    localparam int SW        = $clog2(NUM_STATES);
    localparam int AW        = $clog2(ALPHABET_DEPTH);
    localparam int MEM_DEPTH = (2 ** SW) * (2 ** AW);
    localparam int CW        = (SW > 6) ? SW : 6;
    localparam logic [8:0] NS9 = 9'(NUM_STATES);
    localparam logic [8:0] AD9 = 9'(ALPHABET_DEPTH);
    localparam logic [4:0] AS5 = 5'(ACCEPT_SLOTS);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic [SW-1:0]    mem [MEM_DEPTH];
    logic [SW-1:0]    rdata_reg;
    logic             mem_we, mem_re;
    logic [SW+AW-1:0] waddr, raddr;

    logic             fsm_reg, fsm_next;
    logic [SW-1:0]    state_reg, state_next;
    logic             reject_reg, reject_next;
    logic             pend_last_reg, pend_last_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_acc_reg, out_bad_reg;

    logic             slot_valid_reg [ACCEPT_SLOTS];
    logic [5:0]       slot_state_reg [ACCEPT_SLOTS];
    logic             slot_we;

    logic             out_free, needs_out;
    logic             finish, fin_reject, hit, trans_ok;
    logic [SW-1:0]    hit_state;

    assign out_free  = !out_valid_reg || out_ready;
    assign needs_out = (q_data.kind == tddfa_pkg::K_END) ||
                       (q_data.kind == tddfa_pkg::K_CHAR && q_data.last);
    assign q_pop     = !q_empty && fsm_reg == ST_IDLE && (!needs_out || out_free);

    assign trans_ok = ({3'b0, q_data.from_state} < NS9) &&
                      ({3'b0, q_data.to_state} < NS9) &&
                      ({1'b0, q_data.sym} < AD9);
    assign waddr    = {SW'(q_data.from_state), AW'(q_data.sym)};
    assign raddr    = {state_reg, AW'(q_data.sym)};
    assign slot_we  = q_pop && q_data.kind == tddfa_pkg::K_SWRITE &&
                      ({2'b0, q_data.slot_number} < AS5);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= SW'(q_data.to_state);
        end
        if (mem_re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // final state check against the accept slots
    assign hit_state = (fsm_reg == ST_LOOKUP) ? rdata_reg : state_reg;
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < ACCEPT_SLOTS; k++) begin
            if (slot_valid_reg[k] && CW'(slot_state_reg[k]) == CW'(hit_state)) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        fsm_next       = fsm_reg;
        state_next     = state_reg;
        reject_next    = reject_reg;
        pend_last_next = pend_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        finish         = 1'b0;
        fin_reject     = reject_reg;
        case (fsm_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    case (q_data.kind)
                        tddfa_pkg::K_TWRITE: begin
                            mem_we = trans_ok;
                        end
                        tddfa_pkg::K_END: begin
                            finish = 1'b1;
                        end
                        tddfa_pkg::K_CHAR: begin
                            if (q_data.found) begin
                                mem_re         = 1'b1;
                                pend_last_next = q_data.last;
                                fsm_next       = ST_LOOKUP;
                            end else begin
                                reject_next = 1'b1;
                                fin_reject  = 1'b1;
                                finish      = q_data.last;
                            end
                        end
                        default: begin
                            // slot writes land in the slot registers
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                state_next = rdata_reg;
                fsm_next   = ST_IDLE;
                finish     = pend_last_reg;
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
        if (finish) begin
            state_next  = '0;
            reject_next = 1'b0;
        end
        out_valid_next = finish || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= ST_IDLE;
            state_reg     <= '0;
            reject_reg    <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fsm_reg       <= fsm_next;
            state_reg     <= state_next;
            reject_reg    <= reject_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            out_acc_reg <= !fin_reject && hit;
            out_bad_reg <= fin_reject;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ACCEPT_SLOTS; k++) begin
                slot_valid_reg[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < ACCEPT_SLOTS; k++) begin
                if (slot_we && {2'b0, q_data.slot_number} == 5'(k)) begin
                    slot_valid_reg[k] <= q_data.slot_valid;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < ACCEPT_SLOTS; k++) begin
            if (slot_we && {2'b0, q_data.slot_number} == 5'(k)) begin
                slot_state_reg[k] <= q_data.from_state;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_accepted = out_acc_reg;
    assign out_bad      = out_bad_reg;

endmodule

// File: hdl/table_driven_dfa_recognizer.sv
// path: a string end on a matched character passes the front end registers, the queue,
// the transition memory read and the lookup state before m_tvalid; an empty-string end
// or an unmatched last character skips the memory read and the lookup state; a matched
// character holds the back end in its lookup state, which takes no new queue item
// reset: control, current state, reject flag and accept slots clear at once; the alphabet
// store and transition memory keep their contents and need writing before use
module table_driven_dfa_recognizer #(
    parameter int NUM_STATES     = 64,
    parameter int ALPHABET_DEPTH = 128,
    parameter int ACCEPT_SLOTS   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], symbol_index[14:8], from_state[20:15], to_state[26:21],
    // slot_number[29:27], slot_valid[30], zero[31]
    input  logic [31:0] s_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], bad_character[1], zero[7:2]
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]         alen_reg;
    tddfa_pkg::item_t   item;
    tddfa_pkg::entry_t  push_data, pop_data;
    logic               push, full, pop, empty;
    logic               acc, bad;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, alen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alen_reg <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            alen_reg <= pwdata[7:0];
        end
    end

    assign item.opcode       = s_tuser;
    assign item.char_code    = s_tdata[7:0];
    assign item.symbol_index = s_tdata[14:8];
    assign item.from_state   = s_tdata[20:15];
    assign item.to_state     = s_tdata[26:21];
    assign item.slot_number  = s_tdata[29:27];
    assign item.slot_valid   = s_tdata[30];
    assign item.last         = s_tlast;

    tddfa_front #(
        .ALPHABET_DEPTH (ALPHABET_DEPTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_item         (item),
        .alphabet_length (alen_reg),
        .q_push          (push),
        .q_data          (push_data),
        .q_full          (full)
    );

    tddfa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    tddfa_back #(
        .NUM_STATES     (NUM_STATES),
        .ALPHABET_DEPTH (ALPHABET_DEPTH),
        .ACCEPT_SLOTS   (ACCEPT_SLOTS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (empty),
        .q_data       (pop_data),
        .q_pop        (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_accepted (acc),
        .out_bad      (bad)
    );

    assign m_tdata = {6'd0, bad, acc};

endmodule

// File: bench/tddfa_bench_pkg.sv
`timescale 1ns / 1ps
// verdict scoreboard for the table driven dfa recognizer bench
// depends on tddfa_pkg for item_t and the opcode codes
package tddfa_bench_pkg;

    localparam int ALPHA_DEPTH = 128;
    localparam int NUM_ROWS    = 64;
    localparam int NUM_SLOTS   = 8;
    localparam int HOT_STATES  = 8;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;

    typedef struct packed {
        logic bad_character;
        logic accepted;
    } verdict_t;

    class dfa_scoreboard;
        logic [7:0] alpha [ALPHA_DEPTH];
        logic [5:0] next_state [NUM_ROWS*ALPHA_DEPTH];
        bit         slot_on [NUM_SLOTS];
        logic [5:0] slot_state [NUM_SLOTS];
        logic [5:0] state;
        bit         rejected;
        logic [7:0] alpha_len;
        verdict_t   pending [$];
        int         errors;
        int         verdicts;
        int         accepts;
        int         bad_strings;

        function new();
            foreach (alpha[i]) alpha[i] = '0;
            foreach (next_state[i]) next_state[i] = '0;
            foreach (slot_on[i]) begin
                slot_on[i] = 1'b0;
                slot_state[i] = '0;
            end
            state = '0;
            rejected = 1'b0;
            alpha_len = '0;
            errors = 0;
            verdicts = 0;
            accepts = 0;
            bad_strings = 0;
        endfunction

        // lowest matching entry among the first alpha_len
        function bit find_symbol(input logic [7:0] ch, output int idx);
            int lim;
            lim = (alpha_len > ALPHA_DEPTH) ? ALPHA_DEPTH : alpha_len;
            idx = 0;
            for (int j = 0; j < lim; j++) begin
                if (alpha[j] == ch) begin
                    idx = j;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void end_string();
            bit       hit;
            verdict_t v;
            hit = 1'b0;
            foreach (slot_on[k])
                if (slot_on[k] && slot_state[k] == state) hit = 1'b1;
            v.accepted = !rejected && hit;
            v.bad_character = rejected;
            pending.push_back(v);
            state = '0;
            rejected = 1'b0;
        endfunction

        function void note_input(tddfa_pkg::item_t it);
            int idx;
            case (it.opcode)
                tddfa_pkg::OP_ALPHA: alpha[it.symbol_index] = it.char_code;
                tddfa_pkg::OP_TRANS:
                    next_state[{it.from_state, it.symbol_index}] = it.to_state;
                tddfa_pkg::OP_SLOT: begin
                    slot_on[it.slot_number] = it.slot_valid;
                    slot_state[it.slot_number] = it.from_state;
                end
                tddfa_pkg::OP_CHAR: begin
                    if (find_symbol(it.char_code, idx))
                        state = next_state[{state, idx[6:0]}];
                    else
                        rejected = 1'b1;
                    if (it.last) end_string();
                end
                tddfa_pkg::OP_END: end_string();
                default: ;
            endcase
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(input logic [7:0] data);
            verdict_t v;
            if (pending.size() == 0) begin
                report($sformatf("verdict beat %b with none outstanding", data[1:0]));
                return;
            end
            v = pending.pop_front();
            verdicts++;
            if (v.accepted) accepts++;
            if (v.bad_character) bad_strings++;
            if (data[0] !== v.accepted)
                report($sformatf("verdict %0d accepted %b, want %b",
                                 verdicts, data[0], v.accepted));
            if (data[1] !== v.bad_character)
                report($sformatf("verdict %0d bad_character %b, want %b",
                                 verdicts, data[1], v.bad_character));
        endtask
    endclass

endpackage

// File: bench/tb_table_driven_dfa_recognizer.sv
`timescale 1ns / 1ps
// top level bench for table_driven_dfa_recognizer: stream and apb drivers,
// random stimulus and verdict checking; depends on tddfa_pkg and tddfa_bench_pkg
module tb_table_driven_dfa_recognizer;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int SEGMENT_BEATS = 56;
    localparam logic [2:0] REG_ALPHA_LEN = 3'd0;
    localparam int ALPHA_DEPTH = tddfa_bench_pkg::ALPHA_DEPTH;
    localparam int NUM_ROWS    = tddfa_bench_pkg::NUM_ROWS;
    localparam int NUM_SLOTS   = tddfa_bench_pkg::NUM_SLOTS;
    localparam int HOT_STATES  = tddfa_bench_pkg::HOT_STATES;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tddfa_bench_pkg::dfa_scoreboard sb;
    bit trans_written [NUM_ROWS*ALPHA_DEPTH];
    bit open_string;
    int beats;
    int cycles;
    int send_idle;
    int recv_idle;

    table_driven_dfa_recognizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);

    // random filler in every field, so unused fields are exercised too
    function automatic tddfa_pkg::item_t make_item(input logic [2:0] op);
        logic [63:0]      raw;
        tddfa_pkg::item_t it;
        raw = {$urandom, $urandom};
        it = raw[$bits(tddfa_pkg::item_t)-1:0];
        it.opcode = op;
        return it;
    endfunction

    function automatic logic [5:0] pick_state();
        if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, NUM_ROWS - 1));
        return 6'($urandom_range(0, HOT_STATES - 1));
    endfunction

    function automatic int search_span();
        return (sb.alpha_len > ALPHA_DEPTH) ? ALPHA_DEPTH : sb.alpha_len;
    endfunction

    function automatic logic [7:0] pick_char();
        int lim;
        lim = search_span();
        if (lim != 0 && $urandom_range(0, 99) < 85) return sb.alpha[$urandom_range(0, lim - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input tddfa_pkg::item_t it);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, it.slot_valid, it.slot_number, it.to_state, it.from_state,
                    it.symbol_index, it.char_code};
        s_tuser <= it.opcode;
        s_tlast <= it.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
        if (it.opcode <= tddfa_pkg::OP_END) beats++;
        if (it.opcode == tddfa_pkg::OP_TRANS)
            trans_written[{it.from_state, it.symbol_index}] = 1'b1;
        if (it.opcode == tddfa_pkg::OP_CHAR) open_string = !it.last;
        if (it.opcode == tddfa_pkg::OP_END) open_string = 1'b0;
    endtask

    task automatic send_trans(input logic [5:0] from, input logic [6:0] sym,
                              input logic [5:0] to);
        tddfa_pkg::item_t it;
        it = make_item(tddfa_pkg::OP_TRANS);
        it.from_state = from;
        it.symbol_index = sym;
        it.to_state = to;
        send_item(it);
    endtask

    task automatic send_slot(input logic [2:0] slot, input bit valid, input logic [5:0] st);
        tddfa_pkg::item_t it;
        it = make_item(tddfa_pkg::OP_SLOT);
        it.slot_number = slot;
        it.slot_valid = valid;
        it.from_state = st;
        send_item(it);
    endtask

    task automatic send_alpha(input logic [6:0] idx, input logic [7:0] ch);
        tddfa_pkg::item_t it;
        it = make_item(tddfa_pkg::OP_ALPHA);
        it.symbol_index = idx;
        it.char_code = ch;
        send_item(it);
    endtask

    task automatic send_end();
        send_item(make_item(tddfa_pkg::OP_END));
    endtask

    // a transition that this character would read gets written first
    task automatic send_char(input logic [7:0] ch, input bit last);
        tddfa_pkg::item_t it;
        int               idx;
        if (sb.find_symbol(ch, idx) && !trans_written[{sb.state, idx[6:0]}])
            send_trans(sb.state, idx[6:0], pick_state());
        it = make_item(tddfa_pkg::OP_CHAR);
        it.char_code = ch;
        it.last = last;
        send_item(it);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write then read back; upper write bits are sometimes junk
    task automatic set_alpha_len(input logic [7:0] len);
        logic [31:0] word;
        word = {(($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'h0), len};
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_ALPHA_LEN;
        pwdata <= word;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.alpha_len = len;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {24'h0, len})
            sb.report($sformatf("alphabet length reads %h, want %h", prdata, len));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_step();
        int r;
        int len;
        int lim;
        bit end_by_op;
        r = $urandom_range(0, 99);
        lim = search_span();
        if (r < 60) begin
            len = $urandom_range(0, 6);
            end_by_op = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < len; k++)
                send_char(pick_char(), (k == len - 1) && !end_by_op);
            if (len == 0 || end_by_op) send_end();
        end else if (r < 70) begin
            send_trans(pick_state(),
                       (lim != 0 && $urandom_range(0, 1)) ? 7'($urandom_range(0, lim - 1))
                                                         : 7'($urandom_range(0, 127)),
                       pick_state());
        end else if (r < 78) begin
            send_slot(3'($urandom_range(0, NUM_SLOTS - 1)), $urandom_range(0, 3) != 0,
                      pick_state());
        end else if (r < 83) begin
            send_alpha(7'($urandom_range(0, ALPHA_DEPTH - 1)), 8'($urandom_range(0, 255)));
        end else if (r < 88) begin
            send_item(make_item(tddfa_bench_pkg::OP_FIRST_UNUSED +
                                3'($urandom_range(0, 2))));
        end else begin
            send_char(pick_char(), $urandom_range(0, 2) == 0);
        end
    endtask

    task automatic run_segment(input logic [7:0] len);
        int start;
        set_alpha_len(len);
        start = beats;
        while (beats - start < SEGMENT_BEATS) random_step();
        if (open_string) send_end();
        drain();
    endtask

    initial begin
        logic [7:0] seg_len [6];
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        beats = 0;
        cycles = 0;
        open_string = 1'b0;
        send_idle = 19;
        recv_idle = 84;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty alphabet: every character is bad, slots decide empty strings
        set_alpha_len(8'd0);
        send_end();
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b0);
        send_char(8'h5a, 1'b1);
        for (int k = 0; k < 3; k++)
            send_item(make_item(tddfa_bench_pkg::OP_FIRST_UNUSED + 3'(k)));
        send_slot(3'd0, 1'b1, 6'd0);
        send_end();
        send_slot(3'd7, 1'b1, 6'd63);
        send_slot(3'd3, 1'b0, 6'd0);
        send_end();
        send_slot(3'd0, 1'b0, 6'd0);
        send_end();

        // distinct characters so the flipped low bit is never in the alphabet
        for (int j = 0; j < ALPHA_DEPTH; j++)
            send_alpha(7'(j), {7'(j), 1'($urandom_range(0, 1))});
        drain();

        // length above the store depth searches everything
        set_alpha_len(8'd255);
        send_char(sb.alpha[0], 1'b1);
        send_char(sb.alpha[ALPHA_DEPTH - 1], 1'b1);
        send_char(sb.alpha[3] ^ 8'h01, 1'b1);
        send_char(sb.alpha[5], 1'b0);
        send_char(sb.alpha[40] ^ 8'h01, 1'b0);
        send_char(sb.alpha[9], 1'b1);
        send_char(sb.alpha[1], 1'b0);
        send_char(sb.alpha[2], 1'b0);
        send_end();
        send_trans(6'd63, 7'd127, 6'd63);
        send_trans(6'd0, 7'd127, 6'd63);
        send_char(sb.alpha[ALPHA_DEPTH - 1], 1'b0);
        send_char(sb.alpha[ALPHA_DEPTH - 1], 1'b1);
        drain();

        seg_len = '{8'd128, 8'd1, 8'd255, 8'($urandom_range(2, 127)), 8'd129, 8'd0};
        for (int p = 0; p < 3; p++) begin
            send_idle = (p == 0) ? 19 : (p == 1) ? 84 : 0;
            recv_idle = (p == 0) ? 84 : (p == 1) ? 19 : 0;
            run_segment(seg_len[2*p]);
            run_segment(seg_len[2*p+1]);
        end

        $display("stimulus: %0d input beats over alphabet lengths 0, 1, %0d, 128, 129, 255",
                 beats, seg_len[3]);
        $display("verdicts checked: %0d, accepted %0d, with bad characters %0d",
                 sb.verdicts, sb.accepts, sb.bad_strings);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hdl/tddfa_pkg.sv
hdl/tddfa_front.sv
hdl/tddfa_fifo.sv
hdl/tddfa_back.sv
hdl/table_driven_dfa_recognizer.sv
bench/tddfa_bench_pkg.sv
bench/tb_table_driven_dfa_recognizer.sv
